/* rtl/irm_pkg.sv */
// shared types and constants for the interval range map
// no dependencies; used by irm_cell, irm_chain and interval_range_map
package irm_pkg;

	localparam int KEY_WIDTH       = 32;
	localparam int VALUE_WIDTH     = 8;
	localparam int MAX_BREAKPOINTS = 32;

	typedef enum logic {
		REQ_ASSIGN = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t                     req_type;
		logic signed [KEY_WIDTH-1:0]   key_begin;
		logic signed [KEY_WIDTH-1:0]   key_end;
		logic        [VALUE_WIDTH-1:0] value;
		logic signed [KEY_WIDTH-1:0]   lookup_key;
	} req_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] read_value;
		logic                   overflow;
	} rsp_t;

	// one breakpoint as held in a cell, with its compare flags
	typedef struct packed {
		logic signed [KEY_WIDTH-1:0]   key;
		logic        [VALUE_WIDTH-1:0] val;
		logic                          lt;
		logic                          le;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_CMP  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_INS  = 2'd3
	} cell_op_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		cell_op_t                      op;
		logic signed [KEY_WIDTH-1:0]   key_lo;
		logic signed [KEY_WIDTH-1:0]   key_hi;
		logic signed [KEY_WIDTH-1:0]   new_key;
		logic        [VALUE_WIDTH-1:0] new_val;
	} cell_bus_t;

	// selection results from the row back to the sequencer
	typedef struct packed {
		logic                   lo_hit;
		logic [VALUE_WIDTH-1:0] lo_val;
		logic                   hi_hit;
		logic [VALUE_WIDTH-1:0] hi_val;
		logic                   zone_any;
		logic                   zone_two;
	} sel_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CMP  = 7'b0000010,
		ST_SEL  = 7'b0000100,
		ST_DEL  = 7'b0001000,
		ST_INSE = 7'b0010000,
		ST_INSB = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

/* rtl/irm_cell.sv */
// one breakpoint cell: key, value and compare flags
// depends on irm_pkg; shifts left on delete, right on insert
module irm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  irm_pkg::cell_bus_t bus,
	input  logic              occ,
	input  irm_pkg::entry_t   left,
	input  irm_pkg::entry_t   right,
	output irm_pkg::entry_t   cur
);

	logic signed [irm_pkg::KEY_WIDTH-1:0]   key_q;
	logic        [irm_pkg::VALUE_WIDTH-1:0] val_q;
	logic                                   lt_q;
	logic                                   le_q;
	irm_pkg::entry_t                        nxt;

	assign cur.key = key_q;
	assign cur.val = val_q;
	assign cur.lt  = lt_q;
	assign cur.le  = le_q;

	always_comb begin
		nxt = cur;
		unique case (bus.op)
			irm_pkg::CELL_HOLD: begin
			end
			irm_pkg::CELL_CMP: begin
				nxt.lt = occ && (key_q < bus.key_lo);
				nxt.le = occ && (key_q <= bus.key_hi);
			end
			irm_pkg::CELL_DEL: begin
				// everything from the first non-prefix cell moves one place down
				if (!lt_q) begin
					nxt = right;
				end
			end
			irm_pkg::CELL_INS: begin
				if (!lt_q) begin
					if (left.lt) begin
						nxt.key = bus.new_key;
						nxt.val = bus.new_val;
						nxt.lt  = 1'b0;
						nxt.le  = 1'b0;
					end else begin
						nxt = left;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			le_q <= 1'b0;
		end else begin
			lt_q <= nxt.lt;
			le_q <= nxt.le;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= nxt.key;
		val_q <= nxt.val;
	end

endmodule

/* rtl/irm_chain.sv */
// row of breakpoint cells with last-hit selection and removal-zone detect
// depends on irm_pkg and irm_cell
module irm_chain #(
	parameter int N = irm_pkg::MAX_BREAKPOINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  irm_pkg::cell_bus_t bus,
	input  logic [$clog2(N+1)-1:0] count,
	output irm_pkg::sel_t      sel
);

	localparam int CW = $clog2(N + 1);

	irm_pkg::entry_t ents [N];
	irm_pkg::entry_t edge_lo;
	irm_pkg::entry_t edge_hi;
	logic [N:0]      lt_vec;
	logic [N:0]      le_vec;
	logic [N:0]      zone_vec;

	// left of cell 0 counts as prefix, right of the last cell is empty
	always_comb begin
		edge_lo     = '0;
		edge_lo.lt  = 1'b1;
		edge_hi     = '0;
	end

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			irm_pkg::entry_t l_in;
			irm_pkg::entry_t r_in;
			logic            occ;

			if (i == 0) begin : g_first
				assign l_in = edge_lo;
			end else begin : g_mid_l
				assign l_in = ents[i-1];
			end
			if (i == N - 1) begin : g_last
				assign r_in = edge_hi;
			end else begin : g_mid_r
				assign r_in = ents[i+1];
			end

			assign occ       = CW'(i) < count;
			assign lt_vec[i] = ents[i].lt;
			assign le_vec[i] = ents[i].le;

			irm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.bus    (bus),
				.occ    (occ),
				.left   (l_in),
				.right  (r_in),
				.cur    (ents[i])
			);
		end
	endgenerate

	assign lt_vec[N] = 1'b0;
	assign le_vec[N] = 1'b0;
	assign zone_vec  = le_vec & ~lt_vec;

	// flags form prefixes, so the last set cell is a one-hot pick
	always_comb begin
		sel = '0;
		for (int k = 0; k < N; k++) begin
			if (lt_vec[k] && !lt_vec[k+1]) begin
				sel.lo_hit = 1'b1;
				sel.lo_val = sel.lo_val | ents[k].val;
			end
			if (le_vec[k] && !le_vec[k+1]) begin
				sel.hi_hit = 1'b1;
				sel.hi_val = sel.hi_val | ents[k].val;
			end
			sel.zone_any = sel.zone_any | zone_vec[k];
			sel.zone_two = sel.zone_two | (zone_vec[k] & zone_vec[k+1]);
		end
	end

endmodule

/* rtl/interval_range_map.sv */
// interval range map: a lookup steps through the states CMP, SEL and DONE; an assign
// steps through CMP, SEL, DEL, INSE, INSB and DONE, DEL removing the breakpoints in the
// range one per cycle by the delete shift; an empty, reversed or dropped assign goes
// straight from SEL to DONE like a lookup. one item at a time; a
// stalled result in the output register holds the next item until it is taken.
// arst_n clears the breakpoint count, the default value and the handshake state.
module interval_range_map #(
	parameter int MAX_BREAKPOINTS = irm_pkg::MAX_BREAKPOINTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [irm_pkg::VALUE_WIDTH-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  irm_pkg::req_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output irm_pkg::rsp_t                    out_data
);

	localparam int CW = $clog2(MAX_BREAKPOINTS + 1);
	localparam int EW = $clog2(MAX_BREAKPOINTS + 3);

	irm_pkg::state_t                        state_q;
	logic [CW-1:0]                          count_q;
	logic [irm_pkg::VALUE_WIDTH-1:0]        default_q;
	logic                                   out_valid_q;
	irm_pkg::rsp_t                          out_data_q;

	irm_pkg::req_kind_t                     req_q;
	logic signed [irm_pkg::KEY_WIDTH-1:0]   kb_q;
	logic signed [irm_pkg::KEY_WIDTH-1:0]   ke_q;
	logic        [irm_pkg::VALUE_WIDTH-1:0] val_q;
	logic        [irm_pkg::VALUE_WIDTH-1:0] vend_q;
	logic                                   ins_b_q;
	logic                                   ins_e_q;
	irm_pkg::rsp_t                          res_q;

	irm_pkg::cell_bus_t                     bus;
	irm_pkg::sel_t                          sel;

	logic [irm_pkg::VALUE_WIDTH-1:0]        prev;
	logic [irm_pkg::VALUE_WIDTH-1:0]        vend;
	logic                                   need_b;
	logic                                   need_e;
	logic [EW-1:0]                          grow;
	logic [EW-1:0]                          limit;
	logic                                   ovf;
	logic                                   empty;
	logic                                   in_xfer;
	logic                                   out_load;

	assign in_stall  = state_q != irm_pkg::ST_IDLE;
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == irm_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// values just below key_begin and at key_end, before any change
	assign prev   = sel.lo_hit ? sel.lo_val : default_q;
	assign vend   = sel.hi_hit ? sel.hi_val : default_q;
	assign need_b = val_q != prev;
	assign need_e = vend != val_q;
	assign grow   = EW'(count_q) + EW'(need_b) + EW'(need_e);
	// only up to two removed entries can matter for the overflow check
	assign limit  = EW'(MAX_BREAKPOINTS)
		+ (sel.zone_two ? EW'(2) : (sel.zone_any ? EW'(1) : EW'(0)));
	assign ovf    = grow > limit;
	assign empty  = kb_q >= ke_q;

	always_comb begin
		bus.op      = irm_pkg::CELL_HOLD;
		bus.key_lo  = kb_q;
		bus.key_hi  = ke_q;
		bus.new_key = ke_q;
		bus.new_val = vend_q;
		unique case (state_q)
			irm_pkg::ST_CMP: begin
				bus.op = irm_pkg::CELL_CMP;
			end
			irm_pkg::ST_DEL: begin
				if (sel.zone_any) begin
					bus.op = irm_pkg::CELL_DEL;
				end
			end
			irm_pkg::ST_INSE: begin
				if (ins_e_q) begin
					bus.op = irm_pkg::CELL_INS;
				end
			end
			irm_pkg::ST_INSB: begin
				bus.new_key = kb_q;
				bus.new_val = val_q;
				if (ins_b_q) begin
					bus.op = irm_pkg::CELL_INS;
				end
			end
			default: begin
			end
		endcase
	end

	irm_chain #(
		.N (MAX_BREAKPOINTS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.bus    (bus),
		.count  (count_q),
		.sel    (sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irm_pkg::ST_IDLE;
			count_q     <= '0;
			default_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				default_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				irm_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q <= irm_pkg::ST_CMP;
					end
				end
				irm_pkg::ST_CMP: begin
					state_q <= irm_pkg::ST_SEL;
				end
				irm_pkg::ST_SEL: begin
					if (req_q == irm_pkg::REQ_LOOKUP || empty || ovf) begin
						state_q <= irm_pkg::ST_DONE;
					end else begin
						state_q <= irm_pkg::ST_DEL;
					end
				end
				irm_pkg::ST_DEL: begin
					if (sel.zone_any) begin
						count_q <= count_q - CW'(1);
					end else begin
						state_q <= irm_pkg::ST_INSE;
					end
				end
				irm_pkg::ST_INSE: begin
					if (ins_e_q) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= irm_pkg::ST_INSB;
				end
				irm_pkg::ST_INSB: begin
					if (ins_b_q) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= irm_pkg::ST_DONE;
				end
				irm_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= irm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= irm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= in_data.req_type;
			val_q <= in_data.value;
			kb_q  <= in_data.key_begin;
			// a lookup compares its key on the upper-bound flag
			if (in_data.req_type == irm_pkg::REQ_LOOKUP) begin
				ke_q <= in_data.lookup_key;
			end else begin
				ke_q <= in_data.key_end;
			end
		end
		if (state_q == irm_pkg::ST_SEL) begin
			vend_q  <= vend;
			ins_b_q <= need_b;
			ins_e_q <= need_e;
			if (req_q == irm_pkg::REQ_LOOKUP) begin
				res_q <= '{read_value: vend, overflow: 1'b0};
			end else begin
				res_q <= '{read_value: '0, overflow: !empty && ovf};
			end
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for interval_range_map: random and directed assign/lookup traffic
// with a breakpoint-table predictor; depends on irm_pkg and the interval_range_map rtl
module tb_top;

	typedef logic signed [irm_pkg::KEY_WIDTH-1:0] key_t;
	typedef logic [irm_pkg::VALUE_WIDTH-1:0] val_t;

	localparam key_t KEY_MIN = {1'b1, {(irm_pkg::KEY_WIDTH-1){1'b0}}};
	localparam key_t KEY_MAX = {1'b0, {(irm_pkg::KEY_WIDTH-1){1'b1}}};
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_AT = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	val_t cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	irm_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	irm_pkg::rsp_t out_data;

	interval_range_map uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// predicted breakpoint table
	key_t bp_key [irm_pkg::MAX_BREAKPOINTS];
	val_t bp_val [irm_pkg::MAX_BREAKPOINTS];
	int   bp_count = 0;
	val_t dflt_val = '0;

	irm_pkg::req_t pending_req[$];
	irm_pkg::rsp_t expected_rsp[$];

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int items_sent = 0;
	int n_lookup = 0;
	int n_assign = 0;
	int n_dropped = 0;
	int n_checked = 0;
	int n_errors = 0;
	int idle_cycles = 0;

	function automatic val_t value_for(key_t k);
		val_t v;
		v = dflt_val;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] <= k) v = bp_val[i];
			else break;
		end
		return v;
	endfunction

	// returns 1 when the new table would not fit
	function automatic logic range_assign(key_t kb, key_t ke, val_t v);
		key_t tk [irm_pkg::MAX_BREAKPOINTS+2];
		val_t tv [irm_pkg::MAX_BREAKPOINTS+2];
		val_t prev;
		val_t vend;
		int i;
		int n;
		if (kb >= ke) return 1'b0;
		prev = dflt_val;
		vend = value_for(ke);
		i = 0;
		n = 0;
		while (i < bp_count && bp_key[i] < kb) begin
			tk[n] = bp_key[i];
			tv[n] = bp_val[i];
			prev = bp_val[i];
			n++;
			i++;
		end
		if (v != prev) begin
			tk[n] = kb;
			tv[n] = v;
			n++;
		end
		while (i < bp_count && bp_key[i] <= ke) i++;
		if (vend != v) begin
			tk[n] = ke;
			tv[n] = vend;
			n++;
		end
		while (i < bp_count) begin
			tk[n] = bp_key[i];
			tv[n] = bp_val[i];
			n++;
			i++;
		end
		if (n > irm_pkg::MAX_BREAKPOINTS) return 1'b1;
		for (int j = 0; j < n; j++) begin
			bp_key[j] = tk[j];
			bp_val[j] = tv[j];
		end
		bp_count = n;
		return 1'b0;
	endfunction

	function automatic irm_pkg::rsp_t predict_rsp(irm_pkg::req_t r);
		irm_pkg::rsp_t p;
		p = '0;
		if (r.req_type == irm_pkg::REQ_ASSIGN)
			p.overflow = range_assign(r.key_begin, r.key_end, r.value);
		else
			p.read_value = value_for(r.lookup_key);
		return p;
	endfunction

	// mostly a narrow window so ranges overlap and the table fragments
	function automatic key_t pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return key_t'(int'($urandom_range(0, 200)) - 100);
		if (r < 90) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MIN + 1;
				2: return KEY_MAX - 1;
				default: return KEY_MAX;
			endcase
		end
		return key_t'($urandom);
	endfunction

	function automatic irm_pkg::req_t rand_req();
		irm_pkg::req_t r;
		int m;
		r.key_begin = key_t'($urandom);
		r.key_end = key_t'($urandom);
		r.value = val_t'($urandom);
		r.lookup_key = key_t'($urandom);
		if ($urandom_range(0, 99) < 55) begin
			r.req_type = irm_pkg::REQ_ASSIGN;
			r.key_begin = pick_key();
			m = $urandom_range(0, 99);
			if (m < 70) r.key_end = r.key_begin + key_t'($urandom_range(1, 12));
			else if (m < 80) r.key_end = r.key_begin - key_t'($urandom_range(0, 3));
			else r.key_end = pick_key();
			m = $urandom_range(0, 99);
			if (m < 50) r.value = val_t'($urandom_range(0, 3));
			else if (m < 58) r.value = '1;
			else if (m < 65) r.value = '0;
		end else begin
			r.req_type = irm_pkg::REQ_LOOKUP;
			if ($urandom_range(0, 99) < 80) r.lookup_key = pick_key();
		end
		return r;
	endfunction

	function automatic irm_pkg::req_t mk_assign(key_t kb, key_t ke, val_t v);
		irm_pkg::req_t r;
		r = rand_req();
		r.req_type = irm_pkg::REQ_ASSIGN;
		r.key_begin = kb;
		r.key_end = ke;
		r.value = v;
		return r;
	endfunction

	function automatic irm_pkg::req_t mk_lookup(key_t k);
		irm_pkg::req_t r;
		r = rand_req();
		r.req_type = irm_pkg::REQ_LOOKUP;
		r.lookup_key = k;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	task automatic write_default(val_t v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		dflt_val = v;
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_req.size() != 0 || in_valid || expected_rsp.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic queue_random(int n);
		repeat (n) pending_req.push_back(rand_req());
	endtask

	// driver: predicts on each transfer, then picks the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_rsp.push_back(predict_rsp(in_data));
				items_sent++;
				if (in_data.req_type == irm_pkg::REQ_LOOKUP) n_lookup++;
				else n_assign++;
				if (expected_rsp[$].overflow) n_dropped++;
			end
			if (!in_valid || !in_stall) begin
				// one pause until every result is back
				if (pending_req.size() != 0
						&& !(items_sent == HOLD_AT && expected_rsp.size() != 0)
						&& $urandom_range(0, 99) >= snd_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_req.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected result, read_value", out_data.read_value, 0);
				end else begin
					if (out_data.read_value !== expected_rsp[0].read_value)
						report_mismatch("read_value", out_data.read_value,
							expected_rsp[0].read_value);
					if (out_data.overflow !== expected_rsp[0].overflow)
						report_mismatch("overflow", out_data.overflow,
							expected_rsp[0].overflow);
					void'(expected_rsp.pop_front());
					n_checked++;
				end
			end
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver stalls heavily
		snd_idle_pct = 12;
		rcv_stall_pct = 71;
		write_default('1);
		@(negedge clk);
		pending_req.push_back(mk_lookup(KEY_MIN));
		pending_req.push_back(mk_assign(KEY_MIN, KEY_MAX, '0));
		pending_req.push_back(mk_lookup(KEY_MAX));
		pending_req.push_back(mk_lookup(KEY_MIN));
		// reversed and empty ranges leave the table alone
		pending_req.push_back(mk_assign(KEY_MAX, KEY_MIN, 8'h33));
		pending_req.push_back(mk_assign(key_t'(5), key_t'(5), 8'h44));
		// assigning the default over everything clears the table
		pending_req.push_back(mk_assign(KEY_MIN, KEY_MAX, '1));
		// fill the table to the limit, then one more assign is dropped
		for (int i = 0; i < irm_pkg::MAX_BREAKPOINTS / 2 + 1; i++)
			pending_req.push_back(mk_assign(key_t'(2 * i), key_t'(2 * i + 1), 8'h07));
		pending_req.push_back(mk_lookup(key_t'(3)));
		pending_req.push_back(mk_lookup(key_t'(4)));
		queue_random(180);
		drain();

		// receiver mostly ready, sender idles a lot
		snd_idle_pct = 71;
		rcv_stall_pct = 12;
		write_default('0);
		@(negedge clk);
		queue_random(200);
		drain();

		// back to back
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		write_default(val_t'($urandom));
		@(negedge clk);
		queue_random(100);
		drain();
		write_default(val_t'($urandom));
		@(negedge clk);
		queue_random(100);
		drain();

		$display("covered %0d items: %0d lookups, %0d assigns, %0d dropped on a full table",
			items_sent, n_lookup, n_assign, n_dropped);
		$display("%0d results checked over three stall profiles and four default values",
			n_checked);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
